### sv/blob_gaussian_ellipse_fit_core_macros.svh
// assertion macros for the ellipse fit core
`ifndef BLOB_GAUSSIAN_ELLIPSE_FIT_CORE_MACROS_SVH
`define BLOB_GAUSSIAN_ELLIPSE_FIT_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define BGEF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define BGEF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/bgef_pkg.sv
// shared types, constants and tables of the ellipse fit core
package bgef_pkg;

  localparam int unsigned CNT_W       = 17;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned INT_W       = 16;
  localparam int unsigned OUT_W       = 24;
  localparam int unsigned ANGLE_W     = 14;
  localparam int unsigned SCALE_W     = 12;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned SQ_W        = 48;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;
  localparam logic [OUT_W-1:0]   OUT_MAX     = 24'hFFFFFF;
  localparam int unsigned ANGLE_WRAP  = 11520;
  localparam int               FULL_TURN   = 1474560;
  localparam int               HALF_TURN   = 737280;
  localparam int unsigned CORDIC_STEPS = 16;

  localparam int unsigned MAX_POINTS_DEF = 65536;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // snapshot of one segment's sums
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sr;
    logic [SUM_W-1:0] sc;
    logic [SUM_W-1:0] si;
    logic [SQ_W-1:0]  srr;
    logic [SQ_W-1:0]  scc;
    logic [SQ_W-1:0]  src;
    logic [SQ_W-1:0]  sii;
  } bgef_sums_t;

  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_e;

  typedef struct packed {
    logic         start;
    arith_op_e    op;
    logic [127:0] a;
    logic [63:0]  b;
  } bgef_arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } bgef_arith_rsp_t;

  // atan(2^-i) in 1/4096 degree
  function automatic logic [17:0] cordic_atan(input logic [3:0] i);
    logic [17:0] v;
    case (i)
      4'd0:    v = 18'd184320;
      4'd1:    v = 18'd108810;
      4'd2:    v = 18'd57492;
      4'd3:    v = 18'd29184;
      4'd4:    v = 18'd14649;
      4'd5:    v = 18'd7331;
      4'd6:    v = 18'd3667;
      4'd7:    v = 18'd1833;
      4'd8:    v = 18'd917;
      4'd9:    v = 18'd458;
      4'd10:   v = 18'd229;
      4'd11:   v = 18'd115;
      4'd12:   v = 18'd57;
      4'd13:   v = 18'd29;
      4'd14:   v = 18'd14;
      4'd15:   v = 18'd7;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // clamp to the output range
  function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] v);
    logic [OUT_W-1:0] r;
    r = (v > 64'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    return r;
  endfunction

endpackage

### sv/bgef_front.sv
// pixel front end: product stage and segment accumulators
module bgef_front #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [15:0]             row_coord_i,
  input  logic [15:0]             col_coord_i,
  input  logic [15:0]             pixel_intensity_i,
  input  logic                    last_point_i,
  output logic                    push_o,
  output bgef_pkg::bgef_sums_t    snap_o,
  output logic                    pend_last_o
);
  import bgef_pkg::*;

  localparam int unsigned PW = 2 * COORD_BITS;

  logic [COORD_BITS-1:0] r_in, c_in;
  logic [PW-1:0]         rr_in, cc_in, rc_in;
  logic [2*INT_W-1:0]    vv_in;

  logic                  s1_vld_q, s1_last_q;
  logic [COORD_BITS-1:0] s1_r_q, s1_c_q;
  logic [INT_W-1:0]      s1_v_q;
  logic [PW-1:0]         s1_rr_q, s1_cc_q, s1_rc_q;
  logic [2*INT_W-1:0]    s1_vv_q;

  bgef_sums_t sums_q, sums_d, sums_add;
  logic       add;

  // products of the incoming pixel
  assign r_in  = row_coord_i[COORD_BITS-1:0];
  assign c_in  = col_coord_i[COORD_BITS-1:0];
  assign rr_in = PW'(r_in) * PW'(r_in);
  assign cc_in = PW'(c_in) * PW'(c_in);
  assign rc_in = PW'(r_in) * PW'(c_in);
  assign vv_in = (2*INT_W)'(pixel_intensity_i) * (2*INT_W)'(pixel_intensity_i);

  // product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept_i;
      s1_last_q <= accept_i & last_point_i;
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_r_q  <= r_in;
      s1_c_q  <= c_in;
      s1_v_q  <= pixel_intensity_i;
      s1_rr_q <= rr_in;
      s1_cc_q <= cc_in;
      s1_rc_q <= rc_in;
      s1_vv_q <= vv_in;
    end
  end

  // accumulate unless the segment is already full
  always_comb begin
    add          = s1_vld_q && (sums_q.cnt < CNT_W'(MAX_POINTS));
    sums_add.cnt = sums_q.cnt + CNT_W'(1);
    sums_add.sr  = sums_q.sr  + SUM_W'(s1_r_q);
    sums_add.sc  = sums_q.sc  + SUM_W'(s1_c_q);
    sums_add.si  = sums_q.si  + SUM_W'(s1_v_q);
    sums_add.srr = sums_q.srr + SQ_W'(s1_rr_q);
    sums_add.scc = sums_q.scc + SQ_W'(s1_cc_q);
    sums_add.src = sums_q.src + SQ_W'(s1_rc_q);
    sums_add.sii = sums_q.sii + SQ_W'(s1_vv_q);
    snap_o       = add ? sums_add : sums_q;
    push_o       = s1_vld_q & s1_last_q;
    sums_d       = push_o ? '0 : snap_o;
  end

  assign pend_last_o = s1_vld_q & s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else begin
      sums_q <= sums_d;
    end
  end

endmodule

### sv/bgef_fifo.sv
// short queue of segment snapshots between front and back
module bgef_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bgef_pkg::bgef_sums_t          data_i,
  input  logic                          pop_i,
  output bgef_pkg::bgef_sums_t          data_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o
);
  import bgef_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  bgef_sums_t         mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CW-1:0]      cnt_q;

  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### sv/bgef_arith.sv
// shared bit-serial multiply, divide and square root unit, 64 steps per op
module bgef_arith (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bgef_pkg::bgef_arith_req_t req_i,
  output bgef_pkg::bgef_arith_rsp_t rsp_o
);
  import bgef_pkg::*;

  logic          busy_q, done_q;
  logic [5:0]    cnt_q;
  arith_op_e     op_q;
  logic [63:0]   b_q;
  logic [127:0]  sh_q, acc_q;
  logic [63:0]   root_q;

  logic [127:0]  mul_acc;
  logic [18:0]   div_r, div_rem, div_b;
  logic          div_ge;
  logic [67:0]   sq_r, sq_t, sq_rem;
  logic          sq_ge;

  // one step of each operation
  always_comb begin
    mul_acc = {acc_q[126:0], 1'b0} + (sh_q[127] ? {64'd0, b_q} : 128'd0);
    div_b   = {2'b00, b_q[CNT_W-1:0]};
    div_r   = {acc_q[17:0], sh_q[127]};
    div_ge  = div_r >= div_b;
    div_rem = div_ge ? div_r - div_b : div_r;
    sq_r    = {acc_q[65:0], sh_q[127:126]};
    sq_t    = {2'b00, root_q, 2'b01};
    sq_ge   = sq_r >= sq_t;
    sq_rem  = sq_ge ? sq_r - sq_t : sq_r;
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      op_q   <= req_i.op;
      b_q    <= req_i.b;
      sh_q   <= (req_i.op == ARITH_SQRT) ? req_i.a : {req_i.a[63:0], 64'd0};
      acc_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      case (op_q)
        ARITH_MUL: begin
          acc_q <= mul_acc;
          sh_q  <= {sh_q[126:0], 1'b0};
        end
        ARITH_DIV: begin
          acc_q  <= {109'd0, div_rem};
          root_q <= {root_q[62:0], div_ge};
          sh_q   <= {sh_q[126:0], 1'b0};
        end
        ARITH_SQRT: begin
          acc_q  <= {60'd0, sq_rem};
          root_q <= {root_q[62:0], sq_ge};
          sh_q   <= {sh_q[125:0], 2'b00};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == ARITH_MUL) ? acc_q : {64'd0, root_q};

endmodule

### sv/bgef_back.sv
// back end: per-segment finish sequencer, eigen spreads, means and axis angle
module bgef_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fifo_vld_i,
  input  bgef_pkg::bgef_sums_t          fifo_data_i,
  output logic                          fifo_pop_o,
  input  logic [bgef_pkg::SCALE_W-1:0]  sigma_scale_i,
  output logic                          done_o,
  output logic [bgef_pkg::OUT_W-1:0]    mean_col_o,
  output logic [bgef_pkg::OUT_W-1:0]    mean_row_o,
  output logic [bgef_pkg::OUT_W-1:0]    mean_intensity_o,
  output logic [bgef_pkg::OUT_W-1:0]    minor_spread_o,
  output logic [bgef_pkg::OUT_W-1:0]    major_spread_o,
  output logic [bgef_pkg::OUT_W-1:0]    intensity_spread_o,
  output logic [bgef_pkg::ANGLE_W-1:0]  axis_angle_o,
  output logic [bgef_pkg::CNT_W-1:0]    point_count_o
);
  import bgef_pkg::*;

  localparam int unsigned XY_W = 34;
  localparam int unsigned Z_W  = 23;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_NINIT  = 3'd3;
  localparam logic [2:0] ST_NORM   = 3'd4;
  localparam logic [2:0] ST_CINIT  = 3'd5;
  localparam logic [2:0] ST_CORDIC = 3'd6;
  localparam logic [2:0] ST_ANGLE  = 3'd7;

  localparam logic [4:0] SP_NRR   = 5'd0;
  localparam logic [4:0] SP_A     = 5'd1;
  localparam logic [4:0] SP_NCC   = 5'd2;
  localparam logic [4:0] SP_C     = 5'd3;
  localparam logic [4:0] SP_NII   = 5'd4;
  localparam logic [4:0] SP_I     = 5'd5;
  localparam logic [4:0] SP_NRC   = 5'd6;
  localparam logic [4:0] SP_B     = 5'd7;
  localparam logic [4:0] SP_DM2   = 5'd8;
  localparam logic [4:0] SP_Q     = 5'd9;
  localparam logic [4:0] SP_EIG   = 5'd10;
  localparam logic [4:0] SP_MIN_M = 5'd11;
  localparam logic [4:0] SP_MIN_S = 5'd12;
  localparam logic [4:0] SP_MIN_D = 5'd13;
  localparam logic [4:0] SP_MAJ_M = 5'd14;
  localparam logic [4:0] SP_MAJ_S = 5'd15;
  localparam logic [4:0] SP_MAJ_D = 5'd16;
  localparam logic [4:0] SP_INT_M = 5'd17;
  localparam logic [4:0] SP_INT_S = 5'd18;
  localparam logic [4:0] SP_INT_D = 5'd19;
  localparam logic [4:0] SP_MCOL  = 5'd20;
  localparam logic [4:0] SP_MROW  = 5'd21;
  localparam logic [4:0] SP_MINT  = 5'd22;

  localparam logic signed [Z_W-1:0] Z_FULL = Z_W'(FULL_TURN);
  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(HALF_TURN);
  localparam logic signed [Z_W-1:0] Z_RND  = Z_W'(64);

  logic [2:0]  state_q;
  logic [4:0]  step_q;
  logic        done_q;

  logic [CNT_W-1:0] n_q;
  logic [SUM_W-1:0] sr_q, sc_q, si_q;
  logic [SQ_W-1:0]  srr_q, scc_q, src_q, sii_q;
  logic [63:0]      tmp_q, a_q, c_q, i_q, b_q, maj_q, min_q;
  logic [127:0]     wq_q;
  logic [OUT_W-1:0] mcol_q, mrow_q, mint_q, minsp_q, majsp_q, intsp_q;
  logic [ANGLE_W-1:0] angle_q;

  logic [63:0]      xm_q, ym_q;
  logic             xneg_q, yneg_q;
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic [3:0]       it_q;

  bgef_arith_req_t req;
  bgef_arith_rsp_t rsp;

  logic        bneg;
  logic [63:0] bmag, dm, b2, res64, mx;
  logic [64:0] t_sum, dcl;
  logic [65:0] maj_sum, min_dif;
  logic [OUT_W-1:0] s2;
  logic [63:0] div_col, div_row, div_int;
  logic signed [XY_W-1:0] x0, y0, dx, dy;
  logic signed [Z_W-1:0]  tab, zw, zr;
  logic        flip;

  bgef_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // covariance terms and eigenvalue split
  always_comb begin
    bneg    = b_q[63];
    bmag    = bneg ? 64'd0 - b_q : b_q;
    dm      = (a_q > c_q) ? a_q - c_q : c_q - a_q;
    b2      = {bmag[62:0], 1'b0};
    t_sum   = {1'b0, a_q} + {1'b0, c_q};
    res64   = rsp.res[63:0];
    dcl     = ({1'b0, res64} > t_sum) ? t_sum : {1'b0, res64};
    maj_sum = {1'b0, t_sum} + {1'b0, dcl};
    min_dif = {1'b0, t_sum} - {1'b0, dcl};
    s2      = OUT_W'(sigma_scale_i) * OUT_W'(sigma_scale_i);
    div_col = {24'd0, sc_q, 8'd0} + 64'(n_q[CNT_W-1:1]);
    div_row = {24'd0, sr_q, 8'd0} + 64'(n_q[CNT_W-1:1]);
    div_int = {24'd0, si_q, 8'd0} + 64'(n_q[CNT_W-1:1]);
  end

  // operation program
  always_comb begin
    req.start = (state_q == ST_ISSUE);
    req.op    = ARITH_MUL;
    req.a     = '0;
    req.b     = '0;
    case (step_q)
      SP_NRR:   begin req.a = 128'(n_q);  req.b = 64'(srr_q); end
      SP_A:     begin req.a = 128'(sr_q); req.b = 64'(sr_q);  end
      SP_NCC:   begin req.a = 128'(n_q);  req.b = 64'(scc_q); end
      SP_C:     begin req.a = 128'(sc_q); req.b = 64'(sc_q);  end
      SP_NII:   begin req.a = 128'(n_q);  req.b = 64'(sii_q); end
      SP_I:     begin req.a = 128'(si_q); req.b = 64'(si_q);  end
      SP_NRC:   begin req.a = 128'(n_q);  req.b = 64'(src_q); end
      SP_B:     begin req.a = 128'(sr_q); req.b = 64'(sc_q);  end
      SP_DM2:   begin req.a = 128'(dm);   req.b = dm;         end
      SP_Q:     begin req.a = 128'(b2);   req.b = b2;         end
      SP_EIG:   begin req.op = ARITH_SQRT; req.a = wq_q; end
      SP_MIN_M: begin req.a = 128'(min_q); req.b = 64'(s2); end
      SP_MAJ_M: begin req.a = 128'(maj_q); req.b = 64'(s2); end
      SP_INT_M: begin req.a = 128'(i_q);   req.b = 64'(s2); end
      SP_MIN_S, SP_MAJ_S, SP_INT_S: begin
        req.op = ARITH_SQRT;
        req.a  = wq_q;
      end
      SP_MIN_D, SP_MAJ_D, SP_INT_D: begin
        req.op = ARITH_DIV;
        req.a  = 128'(tmp_q);
        req.b  = 64'(n_q);
      end
      SP_MCOL:  begin req.op = ARITH_DIV; req.a = 128'(div_col); req.b = 64'(n_q); end
      SP_MROW:  begin req.op = ARITH_DIV; req.a = 128'(div_row); req.b = 64'(n_q); end
      SP_MINT:  begin req.op = ARITH_DIV; req.a = 128'(div_int); req.b = 64'(n_q); end
      default:  begin req.op = ARITH_MUL; end
    endcase
  end

  // cordic step values
  always_comb begin
    mx   = (xm_q > ym_q) ? xm_q : ym_q;
    flip = xneg_q && (xm_q != 64'd0);
    x0   = $signed({4'd0, xm_q[29:0]});
    y0   = (yneg_q ^ flip) ? -$signed({4'd0, ym_q[29:0]}) : $signed({4'd0, ym_q[29:0]});
    dx   = y_q >>> it_q;
    dy   = x_q >>> it_q;
    tab  = $signed({5'd0, cordic_atan(it_q)});
    zw   = (z_q < 0) ? z_q + Z_FULL : ((z_q >= Z_FULL) ? z_q - Z_FULL : z_q);
    zr   = zw + Z_RND;
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SP_NRR;
      done_q  <= 1'b0;
      it_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (fifo_vld_i) begin
            state_q <= ST_ISSUE;
            step_q  <= SP_NRR;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp.done) begin
            if (step_q == SP_MINT) begin
              state_q <= ST_NINIT;
            end else begin
              step_q  <= step_q + 5'd1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_NINIT: begin
          if (dm == 64'd0 && b2 == 64'd0) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (mx[63:30] == '0 && mx[29]) begin
            state_q <= ST_CINIT;
          end
        end
        ST_CINIT: begin
          it_q    <= '0;
          state_q <= ST_CORDIC;
        end
        ST_CORDIC: begin
          it_q <= it_q + 4'd1;
          if (it_q == 4'(CORDIC_STEPS - 1)) begin
            state_q <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (fifo_vld_i) begin
          n_q   <= fifo_data_i.cnt;
          sr_q  <= fifo_data_i.sr;
          sc_q  <= fifo_data_i.sc;
          si_q  <= fifo_data_i.si;
          srr_q <= fifo_data_i.srr;
          scc_q <= fifo_data_i.scc;
          src_q <= fifo_data_i.src;
          sii_q <= fifo_data_i.sii;
        end
      end
      ST_WAIT: begin
        if (rsp.done) begin
          case (step_q)
            SP_NRR, SP_NCC, SP_NII, SP_NRC, SP_MIN_S, SP_MAJ_S, SP_INT_S: begin
              tmp_q <= res64;
            end
            SP_A:     a_q <= tmp_q - res64;
            SP_C:     c_q <= tmp_q - res64;
            SP_I:     i_q <= tmp_q - res64;
            SP_B:     b_q <= tmp_q - res64;
            SP_DM2, SP_MIN_M, SP_MAJ_M, SP_INT_M: begin
              wq_q <= rsp.res;
            end
            SP_Q:     wq_q <= wq_q + rsp.res;
            SP_EIG: begin
              maj_q <= maj_sum[64:1];
              min_q <= min_dif[64:1];
            end
            SP_MIN_D: minsp_q <= sat_out(res64);
            SP_MAJ_D: majsp_q <= sat_out(res64);
            SP_INT_D: intsp_q <= sat_out(res64);
            SP_MCOL:  mcol_q  <= sat_out(res64);
            SP_MROW:  mrow_q  <= sat_out(res64);
            SP_MINT:  mint_q  <= sat_out(res64);
            default:  tmp_q   <= tmp_q;
          endcase
        end
      end
      ST_NINIT: begin
        xneg_q  <= a_q < c_q;
        yneg_q  <= !bneg && (bmag != 64'd0);
        xm_q    <= dm;
        ym_q    <= b2;
        angle_q <= '0;
      end
      ST_NORM: begin
        // bring the larger operand into [2^29, 2^30)
        if (mx[63:30] != '0) begin
          xm_q <= {1'b0, xm_q[63:1]};
          ym_q <= {1'b0, ym_q[63:1]};
        end else if (!mx[29]) begin
          xm_q <= {xm_q[62:0], 1'b0};
          ym_q <= {ym_q[62:0], 1'b0};
        end
      end
      ST_CINIT: begin
        // half-plane pre-rotation
        x_q <= x0;
        y_q <= y0;
        z_q <= flip ? Z_HALF : '0;
      end
      ST_CORDIC: begin
        if (!y_q[XY_W-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + tab;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - tab;
        end
      end
      ST_ANGLE: begin
        // halve, round to 1/64 degree, fold a half turn to zero
        if (zr[Z_W-1:7] >= 16'(ANGLE_WRAP)) begin
          angle_q <= '0;
        end else begin
          angle_q <= zr[ANGLE_W+6:7];
        end
      end
      default: begin
        tmp_q <= tmp_q;
      end
    endcase
  end

  assign fifo_pop_o         = (state_q == ST_IDLE) && fifo_vld_i;
  assign done_o             = done_q;
  assign mean_col_o         = mcol_q;
  assign mean_row_o         = mrow_q;
  assign mean_intensity_o   = mint_q;
  assign minor_spread_o     = minsp_q;
  assign major_spread_o     = majsp_q;
  assign intensity_spread_o = intsp_q;
  assign axis_angle_o       = angle_q;
  assign point_count_o      = n_q;

endmodule

### sv/blob_gaussian_ellipse_fit_core.sv
// top level of the segment ellipse fit core
// Pixels of a segment are taken one per cycle on start/busy and summed exactly;
// the pixel with last_point_i set closes the segment and its sums move into a
// two-entry queue. A back end then works the finish through one shared
// bit-serial multiply/divide/square-root unit: 23 operations, then a
// normalizing shift and a 16-step CORDIC for the axis angle, both of which
// an isotropic shape skips. busy is high only while the queue has no room
// for another closed segment. Each result is shown for exactly one cycle with
// result_valid_o high and cannot be held off by the receiver.
// sigma_scale is written on the cfg channel, which is always ready.
module blob_gaussian_ellipse_fit_core #(
  parameter int unsigned MAX_POINTS = bgef_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = bgef_pkg::COORD_BITS_DEF,
  parameter int unsigned FIFO_DEPTH = bgef_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bgef_pkg::COORD_W-1:0]  row_coord_i,
  input  logic [bgef_pkg::COORD_W-1:0]  col_coord_i,
  input  logic [bgef_pkg::INT_W-1:0]    pixel_intensity_i,
  input  logic                          last_point_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bgef_pkg::SCALE_W-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [bgef_pkg::OUT_W-1:0]    mean_col_o,
  output logic [bgef_pkg::OUT_W-1:0]    mean_row_o,
  output logic [bgef_pkg::OUT_W-1:0]    mean_intensity_o,
  output logic [bgef_pkg::OUT_W-1:0]    minor_spread_o,
  output logic [bgef_pkg::OUT_W-1:0]    major_spread_o,
  output logic [bgef_pkg::OUT_W-1:0]    intensity_spread_o,
  output logic [bgef_pkg::ANGLE_W-1:0]  axis_angle_o,
  output logic [bgef_pkg::CNT_W-1:0]    point_count_o
);
  import bgef_pkg::*;

`include "blob_gaussian_ellipse_fit_core_macros.svh"

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [SCALE_W-1:0] sigma_scale_q;
  logic               accept, fifo_push, fifo_pop, pend_last;
  bgef_sums_t         snap, fifo_data;
  logic [CW-1:0]      fifo_cnt;

  // scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      sigma_scale_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // hold off pixels while no queue slot is left for a closing segment
  assign busy   = ({1'b0, fifo_cnt} + (CW + 1)'(pend_last)) >= (CW + 1)'(FIFO_DEPTH);
  assign accept = start & ~busy;

  bgef_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .row_coord_i       (row_coord_i),
    .col_coord_i       (col_coord_i),
    .pixel_intensity_i (pixel_intensity_i),
    .last_point_i      (last_point_i),
    .push_o            (fifo_push),
    .snap_o            (snap),
    .pend_last_o       (pend_last)
  );

  bgef_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (snap),
    .pop_i   (fifo_pop),
    .data_o  (fifo_data),
    .count_o (fifo_cnt)
  );

  bgef_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fifo_vld_i         (fifo_cnt != '0),
    .fifo_data_i        (fifo_data),
    .fifo_pop_o         (fifo_pop),
    .sigma_scale_i      (sigma_scale_q),
    .done_o             (result_valid_o),
    .mean_col_o         (mean_col_o),
    .mean_row_o         (mean_row_o),
    .mean_intensity_o   (mean_intensity_o),
    .minor_spread_o     (minor_spread_o),
    .major_spread_o     (major_spread_o),
    .intensity_spread_o (intensity_spread_o),
    .axis_angle_o       (axis_angle_o),
    .point_count_o      (point_count_o)
  );

  // checks
  `BGEF_ASSERT_NEVER(a_fifo_overflow, fifo_push && (fifo_cnt == CW'(FIFO_DEPTH)), "queue overflow")
  `BGEF_ASSERT(a_result_gap, result_valid_o |=> !result_valid_o, "back-to-back results")
  `BGEF_ASSERT(a_angle_range, result_valid_o |-> (axis_angle_o < ANGLE_W'(ANGLE_WRAP)), "angle range")
  `BGEF_ASSERT(a_count_nonzero, result_valid_o |-> (point_count_o != '0), "empty segment")

endmodule
